// ===== rtl/cpe_pkg.sv =====
`default_nettype none
package cpe_pkg;

  localparam int DVW   = 64;
  localparam int NATAN = 30;

  localparam logic signed [63:0] PI_Q30       = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q30  = PI_Q30 / 2;
  localparam logic signed [63:0] G_Q30        = 64'sd10533407293;
  localparam logic signed [63:0] THIRD_PI_Q30 = 64'sd1124419807;
  localparam logic signed [63:0] GAIN_Q30     = 64'sd652032875;
  localparam logic [63:0]        DT_DIV       = 64'd1000;
  localparam logic [63:0]        DT_HALF      = 64'd500;
  // n / 1000 == (n * DT_RECIP) >> DT_SHIFT for any 32-bit n
  localparam int                 DT_SHIFT     = 38;
  localparam logic [63:0]        DT_RECIP     =
    ((64'd1 << DT_SHIFT) + DT_DIV - 64'd1) / DT_DIV;

  localparam logic [31:0] ATAN_Q30 [NATAN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  typedef enum logic [2:0] {
    REG_CART_MASS, REG_BOB_MASS, REG_ARM_LENGTH, REG_POS_LIMIT,
    REG_START_POS, REG_START_ANGLE, REG_START_SPEED, REG_START_SPIN
  } reg_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mag32(input logic signed [31:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return (e < 0) ? 64'(-e) : 64'(e);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cpe_if.sv =====
`default_nettype none
interface cpe_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] control_force;
  logic signed [31:0] disturbance_force;
  modport source (output valid, mode, control_force, disturbance_force, input ready);
  modport sink   (input valid, mode, control_force, disturbance_force, output ready);
endinterface

interface cpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [18:0] angle;
  logic signed [31:0] speed;
  logic signed [31:0] spin;
  logic               failed;
  modport source (output valid, position, angle, speed, spin, failed, input ready);
  modport sink   (input valid, position, angle, speed, spin, failed, output ready);
endinterface
`default_nettype wire

// ===== rtl/cart_pole_euler_step.sv =====
// Channel  Dir  Payload
// in_i     in   mode, control_force, disturbance_force
// out_i    out  position, angle, speed, spin, failed
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
// A restart beat loads the start registers. Step beat time is set mostly by
// the two 64-step restoring divisions (ddx, ddth);
// angle wraps and dt scalings are reciprocal multiplies on the shared multiplier.
// Reset clears state and config to defaults. A new beat is taken once the
// previous result has left the output register.
`default_nettype none
module cart_pole_euler_step #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  cpe_in_if.sink           in_i,
  cpe_out_if.source        out_i
);

  localparam int ZSH = 30 - FRAC_BITS;
  localparam logic signed [63:0] PI_F =
    (cpe_pkg::PI_Q30 + (64'sd1 <<< (ZSH - 1))) >>> ZSH;
  localparam logic signed [63:0] TWO_PI_F = 2 * PI_F;
  localparam logic signed [63:0] G_F =
    (cpe_pkg::G_Q30 + (64'sd1 <<< (ZSH - 1))) >>> ZSH;
  localparam logic signed [63:0] THIRD_F =
    (cpe_pkg::THIRD_PI_Q30 + (64'sd1 <<< (ZSH - 1))) >>> ZSH;
  // quotient estimate by 2*pi, low by at most one
  localparam int WSH = 31 + $clog2(TWO_PI_F);
  localparam logic signed [63:0] WRAP_RECIP = (64'sd1 <<< WSH) / TWO_PI_F;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_WQ, ST_WR, ST_WRAP_A, ST_CORD, ST_CEND, ST_SS,
    ST_D, ST_T1, ST_T2, ST_T3, ST_T4, ST_GS, ST_GC, ST_N1, ST_DDX, ST_N2,
    ST_DDTH, ST_V, ST_X, ST_W, ST_TH, ST_THW, ST_FIN
  } state_e;

  state_e state_q, ret_q, wret_q;

  logic [31:0]        mc_q, mb_q, len_q;
  logic [30:0]        lim_q;
  logic signed [31:0] spos_q, sspd_q, sspn_q;
  logic signed [18:0] sang_q;

  logic signed [31:0] x_q, th_q, v_q, w_q;
  logic signed [31:0] f_q, s_q, c_q, b1_q, gs_q, ddx_q, ddth_q;
  logic signed [36:0] d_q;

  logic signed [32:0] mul_a_q, mul_b_q;
  logic signed [65:0] prod_q;

  logic [63:0]        rem_q, quo_q, dvs_q;
  logic [5:0]         cnt_q;
  logic               dneg_q;

  logic signed [35:0] cx_q, cy_q, cz_q;
  logic [4:0]         ci_q;
  logic               cneg_q;

  logic               ov_q, ofail_q;
  logic signed [31:0] opos_q, ospd_q, ospn_q;
  logic signed [18:0] oang_q;

  // multiplier result
  logic signed [65:0] prod_rnd;
  logic signed [63:0] mq_full;
  logic signed [31:0] mq;
  assign prod_rnd = (prod_q + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign mq_full  = prod_rnd[63:0];
  assign mq       = cpe_pkg::sat32(mq_full);

  // divider
  logic [63:0]        rem_sh, rem_nx, quo_nx;
  logic               ge;
  logic signed [63:0] quo_s;
  logic signed [31:0] dq;
  assign rem_sh = {rem_q[62:0], quo_q[63]};
  assign ge     = rem_sh >= dvs_q;
  assign rem_nx = ge ? rem_sh - dvs_q : rem_sh;
  assign quo_nx = {quo_q[62:0], ge};
  assign quo_s  = dneg_q ? -$signed(quo_q) : $signed(quo_q);
  assign dq     = cpe_pkg::sat32(quo_s);

  // reciprocal results: remainder by 2*pi, scaling by dt
  logic signed [65:0] wq_sh, dt_sh;
  logic [63:0]        rem_raw, rem_fix;
  logic signed [31:0] dtq;
  assign wq_sh   = prod_q >>> WSH;
  assign dt_sh   = prod_q >>> cpe_pkg::DT_SHIFT;
  assign rem_raw = quo_q - prod_q[63:0];
  assign rem_fix = (rem_raw >= 64'(TWO_PI_F)) ? rem_raw - 64'(TWO_PI_F) : rem_raw;
  assign dtq     = 32'(dneg_q ? -dt_sh : dt_sh);

  // angle wrap from remainder
  logic signed [35:0] wr0, wr1, wr2;
  logic signed [31:0] wang;
  assign wr0  = dneg_q ? -$signed({1'b0, rem_q[34:0]}) : $signed({1'b0, rem_q[34:0]});
  assign wr1  = (wr0 < 0) ? wr0 + 36'(TWO_PI_F) : wr0;
  assign wr2  = (wr1 > 36'(PI_F)) ? wr1 - 36'(TWO_PI_F) : wr1;
  assign wang = wr2[31:0];

  // CORDIC
  logic signed [63:0] z0;
  logic signed [35:0] cxs, cys, cat, cxr, cyr;
  logic signed [31:0] sn, cn;
  assign z0  = 64'(wang) <<< ZSH;
  assign cxs = cx_q >>> ci_q;
  assign cys = cy_q >>> ci_q;
  assign cat = $signed({4'b0, cpe_pkg::ATAN_Q30[ci_q]});
  assign cxr = (cx_q + (36'sd1 <<< (ZSH - 1))) >>> ZSH;
  assign cyr = (cy_q + (36'sd1 <<< (ZSH - 1))) >>> ZSH;
  assign sn  = 32'(cneg_q ? -cyr : cyr);
  assign cn  = 32'(cneg_q ? -cxr : cxr);

  // accumulations
  logic signed [31:0] fsum, vn, xn, wn, thn, b1n, n1n, n2n;
  logic signed [36:0] dsum;
  assign fsum = cpe_pkg::sat32(64'(in_i.control_force) + 64'(in_i.disturbance_force));
  assign vn   = cpe_pkg::sat32(64'(v_q) + 64'(dtq));
  assign xn   = cpe_pkg::sat32(64'(x_q) + 64'(dtq));
  assign wn   = cpe_pkg::sat32(64'(w_q) + 64'(dtq));
  assign thn  = cpe_pkg::sat32(64'(th_q) + 64'(dtq));
  assign b1n  = cpe_pkg::sat32(64'(f_q) - 64'(mq));
  assign n1n  = cpe_pkg::sat32(64'(b1_q) + 64'(mq));
  assign n2n  = cpe_pkg::sat32(64'(gs_q) + 64'(mq));
  assign dsum = $signed({5'b0, mc_q}) + mq_full[36:0];

  logic signed [33:0] xe, lime;
  logic signed [32:0] tha;
  logic               fail;
  assign xe   = 34'(x_q);
  assign lime = $signed({3'b0, lim_q});
  assign tha  = (th_q < 0) ? -33'(th_q) : 33'(th_q);
  assign fail = (xe < -lime) || (xe > lime) || (64'(tha) > THIRD_F);

  assign in_i.ready   = (state_q == ST_IDLE) && (!ov_q || out_i.ready);
  assign out_i.valid    = ov_q;
  assign out_i.position = opos_q;
  assign out_i.angle    = oang_q;
  assign out_i.speed    = ospd_q;
  assign out_i.spin     = ospn_q;
  assign out_i.failed   = ofail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      wret_q  <= ST_IDLE;
      mc_q    <= 32'd655360;
      mb_q    <= 32'd327680;
      len_q   <= 32'd3276800;
      lim_q   <= 31'd6553600;
      spos_q  <= '0;
      sang_q  <= '0;
      sspd_q  <= '0;
      sspn_q  <= '0;
      x_q     <= '0;
      th_q    <= '0;
      v_q     <= '0;
      w_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cpe_pkg::reg_e'(cfg_idx_i))
          cpe_pkg::REG_CART_MASS:   mc_q   <= cfg_data_i;
          cpe_pkg::REG_BOB_MASS:    mb_q   <= cfg_data_i;
          cpe_pkg::REG_ARM_LENGTH:  len_q  <= cfg_data_i;
          cpe_pkg::REG_POS_LIMIT:   lim_q  <= cfg_data_i[30:0];
          cpe_pkg::REG_START_POS:   spos_q <= cfg_data_i;
          cpe_pkg::REG_START_ANGLE: sang_q <= cfg_data_i[18:0];
          cpe_pkg::REG_START_SPEED: sspd_q <= cfg_data_i;
          cpe_pkg::REG_START_SPIN:  sspn_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ov_q && out_i.ready) ov_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid && in_i.ready) begin
            if (in_i.mode) begin
              x_q     <= spos_q;
              th_q    <= 32'(sang_q);
              v_q     <= sspd_q;
              w_q     <= sspn_q;
              state_q <= ST_FIN;
            end else begin
              f_q     <= fsum;
              quo_q   <= cpe_pkg::mag32(th_q);
              dneg_q  <= th_q < 0;
              mul_a_q <= 33'(cpe_pkg::mag32(th_q));
              mul_b_q <= 33'(WRAP_RECIP);
              ret_q   <= ST_WQ;
              wret_q  <= ST_WRAP_A;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_q  <= mul_a_q * mul_b_q;
          state_q <= ret_q;
        end
        ST_DIV: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(cpe_pkg::DVW - 1)) state_q <= ret_q;
        end
        ST_WQ: begin
          mul_a_q <= wq_sh[32:0];
          mul_b_q <= 33'(TWO_PI_F);
          ret_q   <= ST_WR;
          state_q <= ST_MUL;
        end
        ST_WR: begin
          rem_q   <= rem_fix;
          state_q <= wret_q;
        end
        ST_WRAP_A: begin
          cx_q <= 36'(cpe_pkg::GAIN_Q30);
          cy_q <= '0;
          ci_q <= '0;
          if (z0 > cpe_pkg::HALF_PI_Q30) begin
            cz_q   <= 36'(z0 - cpe_pkg::PI_Q30);
            cneg_q <= 1'b1;
          end else if (z0 < -cpe_pkg::HALF_PI_Q30) begin
            cz_q   <= 36'(z0 + cpe_pkg::PI_Q30);
            cneg_q <= 1'b1;
          end else begin
            cz_q   <= 36'(z0);
            cneg_q <= 1'b0;
          end
          state_q <= ST_CORD;
        end
        ST_CORD: begin
          if (cz_q >= 0) begin
            cx_q <= cx_q - cys;
            cy_q <= cy_q + cxs;
            cz_q <= cz_q - cat;
          end else begin
            cx_q <= cx_q + cys;
            cy_q <= cy_q - cxs;
            cz_q <= cz_q + cat;
          end
          ci_q <= ci_q + 5'd1;
          if (ci_q == 5'(CORDIC_STEPS - 1)) state_q <= ST_CEND;
        end
        ST_CEND: begin
          s_q     <= sn;
          c_q     <= cn;
          mul_a_q <= 33'(sn);
          mul_b_q <= 33'(sn);
          ret_q   <= ST_SS;
          state_q <= ST_MUL;
        end
        ST_SS: begin
          mul_a_q <= 33'(mq);
          mul_b_q <= $signed({1'b0, mb_q});
          ret_q   <= ST_D;
          state_q <= ST_MUL;
        end
        ST_D: begin
          d_q     <= (dsum <= 0) ? 37'sd1 : dsum;
          mul_a_q <= 33'(w_q);
          mul_b_q <= 33'(w_q);
          ret_q   <= ST_T1;
          state_q <= ST_MUL;
        end
        ST_T1: begin
          mul_a_q <= 33'(mq);
          mul_b_q <= 33'(s_q);
          ret_q   <= ST_T2;
          state_q <= ST_MUL;
        end
        ST_T2: begin
          mul_a_q <= 33'(mq);
          mul_b_q <= $signed({1'b0, len_q});
          ret_q   <= ST_T3;
          state_q <= ST_MUL;
        end
        ST_T3: begin
          mul_a_q <= 33'(mq);
          mul_b_q <= $signed({1'b0, mb_q});
          ret_q   <= ST_T4;
          state_q <= ST_MUL;
        end
        ST_T4: begin
          b1_q    <= b1n;
          mul_a_q <= 33'(G_F);
          mul_b_q <= 33'(s_q);
          ret_q   <= ST_GS;
          state_q <= ST_MUL;
        end
        ST_GS: begin
          gs_q    <= mq;
          mul_a_q <= 33'(mq);
          mul_b_q <= 33'(c_q);
          ret_q   <= ST_GC;
          state_q <= ST_MUL;
        end
        ST_GC: begin
          mul_a_q <= 33'(mq);
          mul_b_q <= $signed({1'b0, mb_q});
          ret_q   <= ST_N1;
          state_q <= ST_MUL;
        end
        ST_N1: begin
          quo_q   <= cpe_pkg::mag32(n1n) << FRAC_BITS;
          dneg_q  <= n1n < 0;
          rem_q   <= '0;
          dvs_q   <= 64'(d_q);
          cnt_q   <= '0;
          ret_q   <= ST_DDX;
          state_q <= ST_DIV;
        end
        ST_DDX: begin
          ddx_q   <= dq;
          mul_a_q <= 33'(c_q);
          mul_b_q <= 33'(dq);
          ret_q   <= ST_N2;
          state_q <= ST_MUL;
        end
        ST_N2: begin
          quo_q   <= cpe_pkg::mag32(n2n) << FRAC_BITS;
          dneg_q  <= n2n < 0;
          rem_q   <= '0;
          dvs_q   <= (len_q == '0) ? 64'd1 : 64'(len_q);
          cnt_q   <= '0;
          ret_q   <= ST_DDTH;
          state_q <= ST_DIV;
        end
        ST_DDTH: begin
          ddth_q  <= dq;
          dneg_q  <= ddx_q < 0;
          mul_a_q <= 33'(cpe_pkg::mag32(ddx_q) + cpe_pkg::DT_HALF);
          mul_b_q <= 33'(cpe_pkg::DT_RECIP);
          ret_q   <= ST_V;
          state_q <= ST_MUL;
        end
        ST_V: begin
          v_q     <= vn;
          dneg_q  <= vn < 0;
          mul_a_q <= 33'(cpe_pkg::mag32(vn) + cpe_pkg::DT_HALF);
          mul_b_q <= 33'(cpe_pkg::DT_RECIP);
          ret_q   <= ST_X;
          state_q <= ST_MUL;
        end
        ST_X: begin
          x_q     <= xn;
          dneg_q  <= ddth_q < 0;
          mul_a_q <= 33'(cpe_pkg::mag32(ddth_q) + cpe_pkg::DT_HALF);
          mul_b_q <= 33'(cpe_pkg::DT_RECIP);
          ret_q   <= ST_W;
          state_q <= ST_MUL;
        end
        ST_W: begin
          w_q     <= wn;
          dneg_q  <= wn < 0;
          mul_a_q <= 33'(cpe_pkg::mag32(wn) + cpe_pkg::DT_HALF);
          mul_b_q <= 33'(cpe_pkg::DT_RECIP);
          ret_q   <= ST_TH;
          state_q <= ST_MUL;
        end
        ST_TH: begin
          quo_q   <= cpe_pkg::mag32(thn);
          dneg_q  <= thn < 0;
          mul_a_q <= 33'(cpe_pkg::mag32(thn));
          mul_b_q <= 33'(WRAP_RECIP);
          ret_q   <= ST_WQ;
          wret_q  <= ST_THW;
          state_q <= ST_MUL;
        end
        ST_THW: begin
          th_q    <= wang;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          opos_q  <= x_q;
          oang_q  <= th_q[18:0];
          ospd_q  <= v_q;
          ospn_q  <= w_q;
          ofail_q <= fail;
          ov_q    <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/cart_pole_euler_step_tb.sv =====
`default_nettype none
module cart_pole_euler_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FRAC     = 16;
  localparam int  STEPS    = 16;
  localparam int  SETTLE   = 700;
  localparam int  LIMIT    = 1500000;
  localparam int  N_PHASES = 7;

  typedef struct packed {
    logic [31:0] position;
    logic [18:0] angle;
    logic [31:0] speed;
    logic [31:0] spin;
    logic        failed;
  } plant_state_t;

  class plant_scoreboard;
    longint       regs[8];
    longint       x, th, v, w;
    plant_state_t expected_q[$];
    int           errors;

    function new();
      regs = '{655360, 327680, 3276800, 6553600, 0, 0, 0, 0};
      x = 0; th = 0; v = 0; w = 0;
      errors = 0;
    endfunction

    function void set_reg(cpe_pkg::reg_e idx, logic [31:0] val);
      longint m;
      m = (idx == cpe_pkg::REG_POS_LIMIT) ? 64'h7fffffff :
          (idx == cpe_pkg::REG_START_ANGLE) ? 64'h7ffff : 64'hffffffff;
      regs[idx] = longint'({32'd0, val}) & m;
    endfunction

    function longint sat32(longint a);
      if (a > 64'sd2147483647) return 64'sd2147483647;
      if (a < -64'sd2147483648) return -64'sd2147483648;
      return a;
    endfunction

    function longint rnd(longint a, int sh);
      return (a + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function longint mulq(longint a, longint b);
      return sat32(rnd(a * b, FRAC));
    endfunction

    function longint q30(longint a);
      return rnd(a, 30 - FRAC);
    endfunction

    function longint by_dt(longint a);
      if (a >= 0) return (a + 500) / 1000;
      return -((-a + 500) / 1000);
    endfunction

    function longint wrap(longint t);
      longint pi, two, r;
      pi  = q30(cpe_pkg::PI_Q30);
      two = 2 * pi;
      r   = t % two;
      if (r < 0) r += two;
      if (r > pi) r -= two;
      return r;
    endfunction

    function void sin_cos(longint ang, output longint s, output longint c);
      longint z, cx, cy, nx;
      bit     neg;
      z = ang * (64'sd1 <<< (30 - FRAC));
      cx = cpe_pkg::GAIN_Q30; cy = 0; neg = 0;
      if (z > cpe_pkg::PI_Q30 / 2) begin
        z -= cpe_pkg::PI_Q30; neg = 1;
      end else if (z < -(cpe_pkg::PI_Q30 / 2)) begin
        z += cpe_pkg::PI_Q30; neg = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
        if (z >= 0) begin
          nx = cx - (cy >>> i); cy = cy + (cx >>> i);
          z -= longint'(cpe_pkg::ATAN_Q30[i]);
        end else begin
          nx = cx + (cy >>> i); cy = cy - (cx >>> i);
          z += longint'(cpe_pkg::ATAN_Q30[i]);
        end
        cx = nx;
      end
      s = q30(cy);
      c = q30(cx);
      if (neg) begin
        s = -s; c = -c;
      end
    endfunction

    function void note_beat(logic mode, logic signed [31:0] cf, logic signed [31:0] df);
      longint       mc, mb, len, g, f, s, c, d, t, b1, gs, n1, n2, ddx, ddth, a;
      logic [18:0]  a19;
      plant_state_t e;
      if (mode) begin
        x   = longint'(signed'(regs[cpe_pkg::REG_START_POS][31:0]));
        a19 = regs[cpe_pkg::REG_START_ANGLE][18:0];
        th  = longint'(signed'(a19));
        v   = longint'(signed'(regs[cpe_pkg::REG_START_SPEED][31:0]));
        w   = longint'(signed'(regs[cpe_pkg::REG_START_SPIN][31:0]));
      end else begin
        mc  = regs[cpe_pkg::REG_CART_MASS];
        mb  = regs[cpe_pkg::REG_BOB_MASS];
        len = regs[cpe_pkg::REG_ARM_LENGTH];
        g  = q30(cpe_pkg::G_Q30);
        f  = sat32(longint'(cf) + longint'(df));
        sin_cos(wrap(th), s, c);
        d = mc + rnd(mulq(s, s) * mb, FRAC);
        if (d <= 0) d = 1;
        t = mulq(w, w);
        t = mulq(t, s);
        t = mulq(t, len);
        t = mulq(t, mb);
        b1  = sat32(f - t);
        gs  = mulq(g, s);
        n1  = sat32(b1 + mulq(mulq(gs, c), mb));
        ddx = sat32(n1 * (64'sd1 <<< FRAC) / d);
        n2  = sat32(gs + mulq(c, ddx));
        if (len == 0) len = 1;
        ddth = sat32(n2 * (64'sd1 <<< FRAC) / len);
        v  = sat32(v + by_dt(ddx));
        x  = sat32(x + by_dt(v));
        w  = sat32(w + by_dt(ddth));
        th = wrap(sat32(th + by_dt(w)));
      end
      a = (th < 0) ? -th : th;
      e.position = x[31:0];
      e.angle    = th[18:0];
      e.speed    = v[31:0];
      e.spin     = w[31:0];
      e.failed   = (x < -regs[cpe_pkg::REG_POS_LIMIT] || x > regs[cpe_pkg::REG_POS_LIMIT] ||
                    a > q30(cpe_pkg::THIRD_PI_Q30));
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_beat(plant_state_t got);
      plant_state_t e;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (got.position !== e.position)
        report($sformatf("position %h, expected %h", got.position, e.position));
      if (got.angle !== e.angle)
        report($sformatf("angle %h, expected %h", got.angle, e.angle));
      if (got.speed !== e.speed)
        report($sformatf("speed %h, expected %h", got.speed, e.speed));
      if (got.spin !== e.spin)
        report($sformatf("spin %h, expected %h", got.spin, e.spin));
      if (got.failed !== e.failed)
        report($sformatf("failed %b, expected %b", got.failed, e.failed));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  cpe_in_if  in_ch ();
  cpe_out_if out_ch ();

  cart_pole_euler_step i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_i      (out_ch.source)
  );

  plant_scoreboard sb = new();
  int  cycles = 0;
  int  burst_left = 0;
  bit  hold_req = 0;
  int  stall_mode = 0;

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.control_force = '0;
    in_ch.disturbance_force = '0;
    out_ch.ready = 1'b0;
  end

  // accepted beats and result beats, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_beat(in_ch.mode, in_ch.control_force, in_ch.disturbance_force);
      if (out_ch.valid && out_ch.ready)
        sb.check_beat('{out_ch.position, out_ch.angle, out_ch.speed,
                        out_ch.spin, out_ch.failed});
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver stall pattern; long hold-off on request
  initial begin
    int hold_left, window;
    hold_left = 0;
    window = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 3000;
      end
      if (window == 0) begin
        window = $urandom_range(50, 400);
        stall_mode = $urandom_range(0, 2);
      end
      window--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        case (stall_mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = $urandom_range(0, 1);
          default: out_ch.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_beat(logic mode, logic [31:0] cf, logic [31:0] df);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.mode = mode;
    in_ch.control_force = cf;
    in_ch.disturbance_force = df;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cpe_pkg::reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] small_force();
    return $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 200 << 16) - (100 << 16);
  endfunction

  task automatic random_regs(int kind);
    logic [18:0] ang;
    if (kind == 0) begin
      write_reg(cpe_pkg::REG_CART_MASS,  $urandom_range(1 << 14, 50 << 16));
      write_reg(cpe_pkg::REG_BOB_MASS,   $urandom_range(1 << 14, 20 << 16));
      write_reg(cpe_pkg::REG_ARM_LENGTH, $urandom_range(1 << 14, 100 << 16));
      write_reg(cpe_pkg::REG_POS_LIMIT,  $urandom_range(0, 200 << 16));
      write_reg(cpe_pkg::REG_START_POS,  $urandom_range(0, 40 << 16) - (20 << 16));
      ang = $urandom_range(0, 2 * 205887) - 205887;
      write_reg(cpe_pkg::REG_START_ANGLE, {{13{ang[18]}}, ang});
      write_reg(cpe_pkg::REG_START_SPEED, $urandom_range(0, 4 << 16) - (2 << 16));
      write_reg(cpe_pkg::REG_START_SPIN,  $urandom_range(0, 4 << 16) - (2 << 16));
    end else begin
      for (int i = 0; i < 8; i++) write_reg(cpe_pkg::reg_e'(i), $urandom());
    end
  endtask

  initial begin
    logic [31:0] ext[4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults: step from rest, then force extremes, then a restart
    send_beat(1'b0, 32'h0, 32'h0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 2; j++) send_beat(1'b0, ext[i], ext[j]);
    send_beat(1'b1, 32'hffffffff, 32'h7fffffff);
    drain();

    // start near the angle extreme with full spin so the angle wraps
    write_reg(cpe_pkg::REG_START_POS, 32'h7fffffff);
    write_reg(cpe_pkg::REG_START_ANGLE, 32'd205887);
    write_reg(cpe_pkg::REG_START_SPEED, 32'h80000000);
    write_reg(cpe_pkg::REG_START_SPIN, 32'h7fffffff);
    write_reg(cpe_pkg::REG_POS_LIMIT, 32'h7fffffff);
    send_beat(1'b1, '0, '0);
    for (int i = 0; i < 4; i++) send_beat(1'b0, ext[i], 32'h0);
    drain();

    // degenerate masses and lengths
    write_reg(cpe_pkg::REG_CART_MASS, 32'h0);
    write_reg(cpe_pkg::REG_BOB_MASS, 32'hffffffff);
    write_reg(cpe_pkg::REG_ARM_LENGTH, 32'h0);
    write_reg(cpe_pkg::REG_POS_LIMIT, 32'h0);
    write_reg(cpe_pkg::REG_START_ANGLE, 32'hfffcdbc1);
    write_reg(cpe_pkg::REG_START_SPIN, 32'h80000000);
    send_beat(1'b1, '0, '0);
    send_beat(1'b0, 32'h7fffffff, 32'h7fffffff);
    send_beat(1'b0, 32'h80000000, 32'h80000000);
    drain();
    write_reg(cpe_pkg::REG_CART_MASS, 32'hffffffff);
    write_reg(cpe_pkg::REG_BOB_MASS, 32'h1);
    write_reg(cpe_pkg::REG_ARM_LENGTH, 32'hffffffff);
    send_beat(1'b1, '0, '0);
    send_beat(1'b0, 32'h12345678, 32'hedcba987);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      random_regs((p % 3 == 2) ? 1 : 0);
      send_beat(1'b1, $urandom(), $urandom());
      if (p == 1) hold_req = 1;
      repeat (68) begin
        if ($urandom_range(0, 15) == 0) send_beat(1'b1, $urandom(), $urandom());
        else send_beat(1'b0, small_force(), small_force());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== cart_pole_euler_step.f =====
rtl/cpe_pkg.sv
rtl/cpe_if.sv
rtl/cart_pole_euler_step.sv
sim/cart_pole_euler_step_tb.sv
